>>> rtl/core/spf_pkg.sv
// Servo packet framer: shared types and constants.
// Item and command structs, queue sizing, sync byte.
// No dependencies.
package spf_pkg;

  localparam logic [7:0] SyncByte = 8'hFF;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = QPtrW + 1;

  localparam logic KindHeader = 1'b0;
  localparam logic KindParam  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] servo_id;
    logic [7:0] pkt_length;
    logic [7:0] instr_code;
    logic [7:0] param_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic       stray_param;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_PARAM,
    CMD_STRAY
  } cmd_op_e;

  // one classified item, checksum already resolved
  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] data;
    logic [7:0] csum;
    logic       with_csum;
  } cmd_t;

endpackage

>>> rtl/core/spf_if.sv
// Servo packet framer: valid/ready stream interfaces for input and output beats.
// Depends on spf_pkg.
interface spf_in_if;
  logic              valid;
  logic              ready;
  spf_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface spf_out_if;
  logic               valid;
  logic               ready;
  spf_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/core/spf_front.sv
// Servo packet framer front end: accepts input beats, tracks packet state,
// builds one command per beat with its checksum. Depends on spf_pkg, spf_if.
module spf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  spf_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output spf_pkg::cmd_t cmd_o
);
  import spf_pkg::*;

  logic       in_packet_q, in_packet_d;
  logic [7:0] params_left_q, params_left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] hdr_sum;
  logic [7:0] par_sum;
  logic       accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;

  assign hdr_sum = in_i.item.servo_id + in_i.item.pkt_length + in_i.item.instr_code;
  assign par_sum = sum_q + in_i.item.param_byte;

  always_comb begin
    in_packet_d   = in_packet_q;
    params_left_d = params_left_q;
    sum_d         = sum_q;
    cmd_o.op        = CMD_STRAY;
    cmd_o.id        = in_i.item.servo_id;
    cmd_o.len       = in_i.item.pkt_length;
    cmd_o.data      = in_i.item.param_byte;
    cmd_o.csum      = ~par_sum;
    cmd_o.with_csum = 1'b0;
    if (in_i.item.kind == KindHeader) begin
      cmd_o.op        = CMD_HEADER;
      cmd_o.data      = in_i.item.instr_code;
      cmd_o.csum      = ~hdr_sum;
      cmd_o.with_csum = (in_i.item.pkt_length <= 8'd2);
      sum_d           = hdr_sum;
      params_left_d   = (in_i.item.pkt_length > 8'd2) ? (in_i.item.pkt_length - 8'd2) : 8'd0;
      in_packet_d     = (in_i.item.pkt_length > 8'd2);
    end else if (in_packet_q) begin
      cmd_o.op        = CMD_PARAM;
      cmd_o.with_csum = (params_left_q == 8'd1);
      sum_d           = par_sum;
      params_left_d   = params_left_q - 8'd1;
      in_packet_d     = (params_left_q != 8'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q   <= 1'b0;
      params_left_q <= 8'd0;
      sum_q         <= 8'd0;
    end else if (accept) begin
      in_packet_q   <= in_packet_d;
      params_left_q <= params_left_d;
      sum_q         <= sum_d;
    end
  end

endmodule

>>> rtl/core/spf_cmd_queue.sv
// Servo packet framer command queue: small FIFO between front and back end.
// Depends on spf_pkg.
module spf_cmd_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  spf_pkg::cmd_t             cmd_i,
  output logic                      full_o,
  input  logic                      pop_i,
  output spf_pkg::cmd_t             cmd_o,
  output logic                      empty_o,
  output logic [spf_pkg::QCntW-1:0] count_o
);
  import spf_pkg::*;

  cmd_t             store_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign cmd_o   = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

>>> rtl/core/spf_back.sv
// Servo packet framer back end: serialises queued commands into output beats
// through a registered output stage. Depends on spf_pkg, spf_if.
module spf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spf_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  spf_out_if.source     out_o
);
  import spf_pkg::*;

  localparam logic [2:0] StepSync0 = 3'd0;
  localparam logic [2:0] StepSync1 = 3'd1;
  localparam logic [2:0] StepId    = 3'd2;
  localparam logic [2:0] StepLen   = 3'd3;
  localparam logic [2:0] StepIns   = 3'd4;
  localparam logic [2:0] StepHCsum = 3'd5;
  localparam logic [2:0] StepData  = 3'd0;
  localparam logic [2:0] StepPCsum = 3'd1;

  logic [2:0] step_q;
  logic       valid_q;
  out_item_t  item_q;
  out_item_t  beat;
  logic       last;
  logic       load;
  logic       fire;

  assign load  = !valid_q || out_o.ready;
  assign fire  = load && !empty_i;
  assign pop_o = fire && last;

  assign out_o.valid = valid_q;
  assign out_o.item  = item_q;

  always_comb begin
    beat.out_byte      = 8'd0;
    beat.end_of_packet = 1'b0;
    beat.stray_param   = 1'b0;
    last               = 1'b1;
    case (cmd_i.op)
      CMD_HEADER: begin
        last = cmd_i.with_csum ? (step_q == StepHCsum) : (step_q == StepIns);
        case (step_q)
          StepSync0: beat.out_byte = SyncByte;
          StepSync1: beat.out_byte = SyncByte;
          StepId:    beat.out_byte = cmd_i.id;
          StepLen:   beat.out_byte = cmd_i.len;
          StepIns:   beat.out_byte = cmd_i.data;
          default: begin
            beat.out_byte      = cmd_i.csum;
            beat.end_of_packet = 1'b1;
          end
        endcase
      end
      CMD_PARAM: begin
        last = cmd_i.with_csum ? (step_q == StepPCsum) : (step_q == StepData);
        if (step_q == StepData) begin
          beat.out_byte = cmd_i.data;
        end else begin
          beat.out_byte      = cmd_i.csum;
          beat.end_of_packet = 1'b1;
        end
      end
      CMD_STRAY: begin
        beat.stray_param = 1'b1;
      end
      default: begin
        beat.stray_param = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 3'd0;
      valid_q <= 1'b0;
    end else if (fire) begin
      valid_q <= 1'b1;
      step_q  <= last ? 3'd0 : (step_q + 3'd1);
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= beat;
    end
  end

endmodule

>>> rtl/core/servo_packet_framer.sv
// Servo packet framer top level: front end, command queue, back end.
// Depends on spf_pkg, spf_if, spf_front, spf_cmd_queue, spf_back.
//
// Frames servo command packets onto a byte stream. A header beat produces
// five output beats (0xFF, 0xFF, id, length, instruction), plus a sixth, the
// checksum, straight away when length is 2 or less; each parameter beat produces one
// output beat, two on the last parameter of a packet, which carries the
// inverted 8-bit sum with end_of_packet set. A parameter beat outside a packet
// gives one beat with stray_param set and out_byte zero. Input beats are taken
// one per cycle while the four-entry command queue has room; the output port
// delivers one beat per cycle while its sink is ready, so the sustained rate is
// set by output beats: one or two per parameter, five or six per header, with
// the queue absorbing header bursts. Beats pass the queue, then the output register.
module servo_packet_framer (
  input  logic      clk_i,
  input  logic      rst_ni,
  spf_in_if.sink    in_i,
  spf_out_if.source out_o
);
  import spf_pkg::*;

  cmd_t             push_cmd;
  cmd_t             head_cmd;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic [QCntW-1:0] count;

  spf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  spf_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty),
    .count_o (count)
  );

  spf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

`ifndef ASSERT_OFF
  a_eop_not_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.item.end_of_packet |-> !out_o.item.stray_param)
    else $error("end of packet beat flagged as stray");

  a_stray_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.item.stray_param |-> (out_o.item.out_byte == 8'd0))
    else $error("stray beat carries a non-zero byte");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= QCntW'(QueueDepth))
    else $error("command queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("back end popped an empty queue");
`endif

endmodule
